FILE: hdl/box_blur_3x3_rgba_core_macros.svh
// assertion macros used by the box blur checker
`ifndef BOX_BLUR_3X3_RGBA_CORE_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BB3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

  // input transfer payload
  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } out_item_t;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // register indexes, taken from paddr bit 2
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // configuration port geometry
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // sum widths: three pixels per column, nine per window
  localparam int COL_SUM_W = 10;
  localparam int SUM_W     = 12;

  // reciprocals scaled by 2^16, exact for sums up to nine full-scale pixels
  localparam int          RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP_9     = 14'd7282;
  localparam logic [13:0] RECIP_6     = 14'd10923;

  typedef enum logic [1:0] {
    DIV_9,
    DIV_6,
    DIV_4
  } div_sel_t;

  typedef logic [COL_SUM_W-1:0] col_sum_t;

  // column sums of one window plus what the divide stage needs
  typedef struct packed {
    col_sum_t [2:0][2:0] col_sum;   // [column][channel]
    logic                use_left;
    logic                use_right;
    div_sel_t            div_sel;
    logic [7:0]          alpha;
    logic                frame_end;
  } cols_t;

endpackage

`default_nettype wire

FILE: hdl/bb3_mean.sv
`default_nettype none

module bb3_mean
  import bb3_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cols_valid,
  output logic           cols_stall,
  input  wire cols_t     cols,
  output logic           res_valid,
  input  wire logic      res_stall,
  output out_item_t      res
);

  localparam int PROD_W = SUM_W + 14;

  logic                   sum_v_r;
  logic [2:0][SUM_W-1:0]  sum_r;
  logic [2:0][SUM_W-1:0]  sum_nxt;
  div_sel_t               div_r;
  logic [7:0]             alpha_r;
  logic                   fe_r;

  logic                   res_v_r;
  out_item_t              res_r;
  out_item_t              res_nxt;

  logic                   out_ready;
  logic                   sum_ready;
  logic [13:0]            recip;
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][7:0]        mean;

  // ready chain from the output register back
  assign out_ready  = !res_v_r || !res_stall;
  assign sum_ready  = !sum_v_r || out_ready;
  assign cols_stall = !sum_ready;

  // window sum: clipped side columns drop out
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = (cols.use_left ? SUM_W'(cols.col_sum[0][ch]) : '0)
                  + SUM_W'(cols.col_sum[1][ch])
                  + (cols.use_right ? SUM_W'(cols.col_sum[2][ch]) : '0);
    end
  end

  // divide by 9 or 6 through a reciprocal, by 4 through a shift
  assign recip = (div_r == DIV_9) ? RECIP_9 : RECIP_6;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(sum_r[ch]) * PROD_W'(recip);
      case (div_r)
        DIV_9:   mean[ch] = prod[ch][RECIP_SHIFT +: 8];
        DIV_6:   mean[ch] = prod[ch][RECIP_SHIFT +: 8];
        DIV_4:   mean[ch] = sum_r[ch][2 +: 8];
        default: mean[ch] = sum_r[ch][2 +: 8];
      endcase
    end
  end

  always_comb begin
    res_nxt.out_red   = mean[0];
    res_nxt.out_green = mean[1];
    res_nxt.out_blue  = mean[2];
    res_nxt.out_alpha = alpha_r;
    res_nxt.frame_end = fe_r;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_v_r <= cols_valid;
      end
      if (out_ready) begin
        res_v_r <= sum_v_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (cols_valid && sum_ready) begin
      sum_r   <= sum_nxt;
      div_r   <= cols.div_sel;
      alpha_r <= cols.alpha;
      fe_r    <= cols.frame_end;
    end
    if (sum_v_r && out_ready) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

`default_nettype wire

FILE: hdl/box_blur_3x3_rgba_core.sv
// 3x3 box blur for a raster-order rgba pixel stream.
// in_*  : one item per transfer; command pixel carries a pixel, command flush
//         drains one pending result after the last pixel of a frame.
// out_* : one result per transfer with the clipped-window mean of red,
//         green and blue, the centre alpha, and frame_end on the last result.
// cfg_* : register 0 image_width at byte 0, register 1 image_height at byte 4.
//         a write restarts the frame; write only while the block is idle.
// throughput: one item per clock while out_stall is low. the line store is a
//   single memory of one 64-bit entry per column, read at accept and written
//   back as the item leaves its stage, so each column entry is touched once per item.
// the result for pixel (r,c) comes with the item at (r+1,c+1), or (r+2,0)
//   in the last column, and passes the column sum, window sum and result
//   registers. a frame needs image_width+1 flush items after its last pixel.
// reset: counters clear, width 640, height 480; line store is not cleared,
//   entries read before they are written only feed clipped window cells.
// stall: the result register holds while out_stall is high; up to three
//   more result-producing items fill the stages behind it, then in_stall rises.
`default_nettype none

module box_blur_3x3_rgba_core
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW_MIN = $clog2(MAX_WIDTH + 1);
  localparam int WW     = (WW_MIN > 13) ? WW_MIN : 13;
  localparam int RW     = 17;

  typedef struct packed {
    logic [31:0]   px;
    logic [CW-1:0] col;
    logic          emit;
    logic          use_top;
    logic          use_bot;
    logic          use_left;
    logic          use_right;
    div_sel_t      div_sel;
    logic          frame_end;
  } s1_t;

  // configuration registers
  logic [12:0]   width_r;
  logic [15:0]   height_r;
  logic          cfg_wr;

  // effective frame geometry
  logic [WW-1:0] width_ext;
  logic [WW-1:0] w_eff;
  logic [CW-1:0] w_last;
  logic [15:0]   h_last;

  // frame position
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;

  // accept-side decode
  logic          in_acc;
  logic          draining;
  logic          ignore;
  logic          take;
  logic          at_eol;
  logic          col_nz;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;
  logic [2:0]    edges;
  s1_t           s1_nxt;

  // line store stage
  logic          s1_v_r;
  s1_t           s1_r;
  logic          s1_go;
  logic [63:0]   line_mem [MAX_WIDTH];
  logic [63:0]   line_q_r;
  logic          fwd_hit_r;
  logic [63:0]   fwd_data_r;
  logic [63:0]   rd_data;
  logic [63:0]   wr_data;
  logic [31:0]   top_px;
  logic [31:0]   mid_px;

  // window and column sums
  logic [31:0]   win_r   [3][3];
  logic [31:0]   win_nxt [3][3];
  logic          s2_v_r;
  cols_t         s2_r;
  cols_t         s2_nxt;
  logic          s2_ready;
  logic          cols_stall;

  // register port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WIDTH) ? CFG_DW'(width_r) : CFG_DW'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_HEIGHT) begin
        height_r <= cfg_pwdata[15:0];
      end else begin
        width_r <= cfg_pwdata[12:0];
      end
    end
  end

  // clamp width to 2..MAX_WIDTH and height to at least 2
  always_comb begin
    width_ext = WW'(width_r);
    if (width_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    w_last = CW'(w_eff - WW'(1));
    h_last = (height_r < 16'd2) ? 16'd1 : height_r - 16'd1;
  end

  // decode of the item at the input
  assign in_acc   = in_valid && !in_stall;
  assign draining = row_r > {1'b0, h_last};
  assign ignore   = !draining && (in_data.command == CMD_FLUSH);
  assign take     = in_acc && !ignore;
  assign at_eol   = col_r == w_last;
  assign col_nz   = col_r != '0;

  always_comb begin
    s1_nxt.px = (!draining && in_data.command == CMD_PIXEL)
              ? {in_data.alpha, in_data.blue, in_data.green, in_data.red} : '0;
    s1_nxt.col  = col_r;
    s1_nxt.emit = (row_r >= RW'(2)) || (row_r == RW'(1) && col_nz);

    // window centre lags one row and one column
    cr = col_nz ? row_r - RW'(1) : row_r - RW'(2);
    cc = col_nz ? col_r - CW'(1) : w_last;

    s1_nxt.use_top   = cr != '0;
    s1_nxt.use_bot   = cr < {1'b0, h_last};
    s1_nxt.use_left  = cc != '0;
    s1_nxt.use_right = cc != w_last;

    edges = 3'(!s1_nxt.use_top) + 3'(!s1_nxt.use_bot)
          + 3'(!s1_nxt.use_left) + 3'(!s1_nxt.use_right);
    case (edges)
      3'd0:    s1_nxt.div_sel = DIV_9;
      3'd1:    s1_nxt.div_sel = DIV_6;
      default: s1_nxt.div_sel = DIV_4;
    endcase

    s1_nxt.frame_end = s1_nxt.emit && (cr == {1'b0, h_last}) && (cc == w_last);
  end

  // position counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (s1_nxt.frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (at_eol) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // pipeline handshake
  assign s2_ready = !s2_v_r || !cols_stall;
  assign s1_go    = s1_v_r && (!s1_r.emit || s2_ready);
  assign in_stall = s1_v_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (take) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s2_ready) begin
        s2_v_r <= s1_go && s1_r.emit;
      end
    end
  end

  // line store entry per column: upper word row r-1, lower word row r-2
  assign rd_data = fwd_hit_r ? fwd_data_r : line_q_r;
  assign top_px  = rd_data[31:0];
  assign mid_px  = rd_data[63:32];
  assign wr_data = {s1_r.px, mid_px};

  // read at transfer, write back as the item leaves; same-entry bypass
  always_ff @(posedge clk) begin
    if (take) begin
      line_q_r   <= line_mem[col_r];
      fwd_hit_r  <= s1_go && (s1_r.col == col_r);
      fwd_data_r <= wr_data;
      s1_r       <= s1_nxt;
    end
    if (s1_go) begin
      line_mem[s1_r.col] <= wr_data;
    end
  end

  // window shifts left, new column from the line store and the pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top_px;
    win_nxt[1][2] = mid_px;
    win_nxt[2][2] = s1_r.px;
  end

  // column sums with clipped rows dropped
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        s2_nxt.col_sum[j][ch] =
            (s1_r.use_top ? COL_SUM_W'(win_nxt[0][j][8*ch +: 8]) : '0)
          + COL_SUM_W'(win_nxt[1][j][8*ch +: 8])
          + (s1_r.use_bot ? COL_SUM_W'(win_nxt[2][j][8*ch +: 8]) : '0);
      end
    end
    s2_nxt.use_left  = s1_r.use_left;
    s2_nxt.use_right = s1_r.use_right;
    s2_nxt.div_sel   = s1_r.div_sel;
    s2_nxt.alpha     = win_nxt[1][1][31:24];
    s2_nxt.frame_end = s1_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= win_nxt[i][j];
        end
      end
    end
    if (s1_go && s1_r.emit && s2_ready) begin
      s2_r <= s2_nxt;
    end
  end

  // window sum, divide and result register
  bb3_mean u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .cols_valid (s2_v_r),
    .cols_stall (cols_stall),
    .cols       (s2_r),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/bb3_checker.sv
`default_nettype none

`include "box_blur_3x3_rgba_core_macros.svh"

module bb3_checker
  import bb3_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire out_item_t         out_data,
  input wire logic              cfg_psel,
  input wire logic              cfg_penable,
  input wire logic              cfg_pwrite,
  input wire logic [CFG_AW-1:0] cfg_paddr,
  input wire logic [CFG_DW-1:0] cfg_pwdata,
  input wire logic [CFG_DW-1:0] cfg_prdata,
  input wire logic              cfg_pready
);

  // a stalled result holds
  `BB3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // input never stalls while the result register can move
  `BB3_ASSERT_SAME(a_in_free, !(out_valid && out_stall), !in_stall, "input stalled with output free")

  // width readback after a write
  `BB3_ASSERT_NEXT(a_width_rb, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[2] == REG_WIDTH), (cfg_paddr[2] != REG_WIDTH) || (cfg_prdata == CFG_DW'($past(cfg_pwdata[12:0]))), "width readback mismatch")

  // height readback after a write
  `BB3_ASSERT_NEXT(a_height_rb, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[2] == REG_HEIGHT), (cfg_paddr[2] != REG_HEIGHT) || (cfg_prdata == CFG_DW'($past(cfg_pwdata[15:0]))), "height readback mismatch")

endmodule

bind box_blur_3x3_rgba_core bb3_checker u_bb3_checker (.*);

`default_nettype wire
